FILE: sv/mhpq_pkg.sv
// mhpq_pkg: shared types, codes and defaults for the min-heap priority queue.
// Used by the channel interfaces, controller, datapath and top level.
// No dependencies.
package mhpq_pkg;

  localparam int unsigned DEPTH_DEF = 1024;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned TAG_W     = 16;
  localparam int unsigned STATUS_W  = 2;

  localparam logic FUNC_INSERT  = 1'b0;
  localparam logic FUNC_EXTRACT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    RES_INSERTED  = 2'd0,
    RES_EXTRACTED = 2'd1,
    RES_FULL      = 2'd2,
    RES_EMPTY     = 2'd3
  } res_status_e;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic        [TAG_W-1:0] tag;
  } entry_t;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_ROOT,
    RD_LAST,
    RD_PARENT,
    RD_LEFT,
    RD_RIGHT
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_MOVING,
    WR_RDATA,
    WR_CHILD
  } wr_sel_e;

  typedef struct packed {
    rd_sel_e     rd_sel;
    wr_sel_e     wr_sel;
    logic        ld_ins;
    logic        ld_ext;
    logic        ex_root;
    logic        ex_last;
    logic        ld_left;
    logic        up_step;
    logic        dn_step;
    logic        clr_out;
    logic        load_res;
    res_status_e res_status;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_zero;
    logic up_less;
    logic r_in;
    logic l_in;
    logic dn_go;
    logic res_free;
  } stat_t;

endpackage

FILE: sv/mhpq_if.sv
// mhpq_req_if and mhpq_res_if: valid/ready channels of the priority queue.
// Depends on mhpq_pkg for field widths and the default depth.
interface mhpq_req_if;
  logic                            valid;
  logic                            ready;
  logic                            func;
  logic signed [mhpq_pkg::KEY_W-1:0] key;
  logic        [mhpq_pkg::TAG_W-1:0] tag;

  modport source (output valid, func, key, tag, input ready);
  modport sink   (input valid, func, key, tag, output ready);
endinterface

interface mhpq_res_if #(
  parameter int unsigned DEPTH = mhpq_pkg::DEPTH_DEF
);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic                               valid;
  logic                               ready;
  logic        [mhpq_pkg::STATUS_W-1:0] status;
  logic signed [mhpq_pkg::KEY_W-1:0]  out_key;
  logic        [mhpq_pkg::TAG_W-1:0]  out_tag;
  logic        [CNT_W-1:0]            occupancy;

  modport source (output valid, status, out_key, out_tag, occupancy, input ready);
  modport sink   (input valid, status, out_key, out_tag, occupancy, output ready);
endinterface

FILE: sv/mhpq_ctrl.sv
// mhpq_ctrl: sequencer for insert / sift-up and extract / sift-down.
// Depends on mhpq_pkg; drives the datapath by cmd_t, reads stat_t.
module mhpq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic              req_func_i,
  output logic              req_ready_o,
  input  mhpq_pkg::stat_t   stat_i,
  output mhpq_pkg::cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_UP_RD   = 4'd1;
  localparam logic [3:0] S_UP_CMP  = 4'd2;
  localparam logic [3:0] S_EX_ROOT = 4'd3;
  localparam logic [3:0] S_EX_LAST = 4'd4;
  localparam logic [3:0] S_DN_L    = 4'd5;
  localparam logic [3:0] S_DN_R    = 4'd6;
  localparam logic [3:0] S_DN_CMP  = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0]            state_q, state_d;
  mhpq_pkg::res_status_e status_q, status_d;
  logic                  accept;

  assign req_ready_o = (state_q == S_IDLE);
  assign accept      = req_valid_i && req_ready_o;

  always_comb begin
    state_d           = state_q;
    status_d          = status_q;
    cmd_o             = '0;
    cmd_o.rd_sel      = mhpq_pkg::RD_NONE;
    cmd_o.wr_sel      = mhpq_pkg::WR_NONE;
    cmd_o.res_status  = status_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_func_i == mhpq_pkg::FUNC_INSERT) begin
            cmd_o.clr_out = 1'b1;
            if (stat_i.full) begin
              status_d = mhpq_pkg::RES_FULL;
              state_d  = S_DONE;
            end else begin
              status_d     = mhpq_pkg::RES_INSERTED;
              cmd_o.ld_ins = 1'b1;
              state_d      = S_UP_RD;
            end
          end else begin
            if (stat_i.empty) begin
              cmd_o.clr_out = 1'b1;
              status_d      = mhpq_pkg::RES_EMPTY;
              state_d       = S_DONE;
            end else begin
              status_d     = mhpq_pkg::RES_EXTRACTED;
              cmd_o.ld_ext = 1'b1;
              cmd_o.rd_sel = mhpq_pkg::RD_ROOT;
              state_d      = S_EX_ROOT;
            end
          end
        end
      end
      S_UP_RD: begin
        if (stat_i.pos_zero) begin
          cmd_o.wr_sel = mhpq_pkg::WR_MOVING;
          state_d      = S_DONE;
        end else begin
          cmd_o.rd_sel = mhpq_pkg::RD_PARENT;
          state_d      = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat_i.up_less) begin
          cmd_o.wr_sel  = mhpq_pkg::WR_RDATA;
          cmd_o.up_step = 1'b1;
          state_d       = S_UP_RD;
        end else begin
          cmd_o.wr_sel = mhpq_pkg::WR_MOVING;
          state_d      = S_DONE;
        end
      end
      S_EX_ROOT: begin
        cmd_o.ex_root = 1'b1;
        cmd_o.rd_sel  = mhpq_pkg::RD_LAST;
        state_d       = S_EX_LAST;
      end
      S_EX_LAST: begin
        cmd_o.ex_last = 1'b1;
        state_d       = S_DN_L;
      end
      S_DN_L: begin
        if (stat_i.l_in) begin
          cmd_o.rd_sel = mhpq_pkg::RD_LEFT;
          state_d      = S_DN_R;
        end else begin
          cmd_o.wr_sel = mhpq_pkg::WR_MOVING;
          state_d      = S_DONE;
        end
      end
      S_DN_R: begin
        cmd_o.ld_left = 1'b1;
        if (stat_i.r_in) begin
          cmd_o.rd_sel = mhpq_pkg::RD_RIGHT;
        end
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (stat_i.dn_go) begin
          cmd_o.wr_sel  = mhpq_pkg::WR_CHILD;
          cmd_o.dn_step = 1'b1;
          state_d       = S_DN_L;
        end else begin
          cmd_o.wr_sel = mhpq_pkg::WR_MOVING;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        if (stat_i.res_free) begin
          cmd_o.load_res = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= mhpq_pkg::RES_INSERTED;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

endmodule

FILE: sv/mhpq_dp.sv
// mhpq_dp: heap memory, entry count, position and compare datapath,
// plus the result register. Depends on mhpq_pkg; commanded by mhpq_ctrl.
module mhpq_dp #(
  parameter int unsigned DEPTH = mhpq_pkg::DEPTH_DEF,
  parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [mhpq_pkg::KEY_W-1:0]   key_i,
  input  logic        [mhpq_pkg::TAG_W-1:0]   tag_i,
  input  mhpq_pkg::cmd_t                      cmd_i,
  output mhpq_pkg::stat_t                     stat_o,
  output logic                                res_valid_o,
  input  logic                                res_ready_i,
  output logic        [mhpq_pkg::STATUS_W-1:0] status_o,
  output logic signed [mhpq_pkg::KEY_W-1:0]   out_key_o,
  output logic        [mhpq_pkg::TAG_W-1:0]   out_tag_o,
  output logic        [CNT_W-1:0]             occupancy_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  mhpq_pkg::entry_t heap_mem [DEPTH];

  logic [CNT_W-1:0]        count_q;
  logic [AW-1:0]           pos_q;
  mhpq_pkg::entry_t        moving_q, left_q, out_q, rdata_q;
  logic                    left_less_q;

  logic [AW+1:0]           l_idx, r_idx, cnt_ext;
  logic [AW-1:0]           pos_m1, parent, rd_addr;
  logic [CNT_W-1:0]        cnt_m1;
  logic                    rd_en, wr_en, right_pick;
  logic signed [mhpq_pkg::KEY_W-1:0] best_key;
  mhpq_pkg::entry_t        wdata;

  logic                    res_valid_q;
  logic [mhpq_pkg::STATUS_W-1:0] res_status_q;
  mhpq_pkg::entry_t        res_entry_q;
  logic [CNT_W-1:0]        res_cnt_q;

  assign l_idx   = {1'b0, pos_q, 1'b1};
  assign r_idx   = l_idx + (AW+2)'(1);
  assign cnt_ext = (AW+2)'(count_q);
  assign pos_m1  = pos_q - AW'(1);
  assign parent  = pos_m1 >> 1;
  assign cnt_m1  = count_q - CNT_W'(1);

  assign best_key   = left_less_q ? left_q.key : moving_q.key;
  assign right_pick = (r_idx < cnt_ext) && ($signed(rdata_q.key) < best_key);

  assign stat_o.full     = (count_q == CNT_W'(DEPTH));
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.pos_zero = (pos_q == '0);
  assign stat_o.up_less  = ($signed(moving_q.key) < $signed(rdata_q.key));
  assign stat_o.l_in     = (l_idx < cnt_ext);
  assign stat_o.r_in     = (r_idx < cnt_ext);
  assign stat_o.dn_go    = right_pick || left_less_q;
  assign stat_o.res_free = !res_valid_q || res_ready_i;

  always_comb begin
    rd_addr = '0;
    unique case (cmd_i.rd_sel)
      mhpq_pkg::RD_NONE:   rd_addr = '0;
      mhpq_pkg::RD_ROOT:   rd_addr = '0;
      mhpq_pkg::RD_LAST:   rd_addr = cnt_m1[AW-1:0];
      mhpq_pkg::RD_PARENT: rd_addr = parent;
      mhpq_pkg::RD_LEFT:   rd_addr = l_idx[AW-1:0];
      mhpq_pkg::RD_RIGHT:  rd_addr = r_idx[AW-1:0];
      default:             rd_addr = '0;
    endcase
  end
  assign rd_en = (cmd_i.rd_sel != mhpq_pkg::RD_NONE);

  always_comb begin
    wdata = moving_q;
    unique case (cmd_i.wr_sel)
      mhpq_pkg::WR_NONE:   wdata = moving_q;
      mhpq_pkg::WR_MOVING: wdata = moving_q;
      mhpq_pkg::WR_RDATA:  wdata = rdata_q;
      mhpq_pkg::WR_CHILD:  wdata = right_pick ? rdata_q : left_q;
      default:             wdata = moving_q;
    endcase
  end
  assign wr_en = (cmd_i.wr_sel != mhpq_pkg::WR_NONE);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      heap_mem[pos_q] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= heap_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.ld_ins) begin
      count_q <= count_q + CNT_W'(1);
    end else if (cmd_i.ex_root) begin
      count_q <= cnt_m1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_ins) begin
      pos_q        <= count_q[AW-1:0];
      moving_q.key <= key_i;
      moving_q.tag <= tag_i;
    end else if (cmd_i.ld_ext) begin
      pos_q <= '0;
    end else if (cmd_i.up_step) begin
      pos_q <= parent;
    end else if (cmd_i.dn_step) begin
      pos_q <= right_pick ? r_idx[AW-1:0] : l_idx[AW-1:0];
    end
    if (cmd_i.ex_last) begin
      moving_q <= rdata_q;
    end
    if (cmd_i.ld_left) begin
      left_q      <= rdata_q;
      left_less_q <= ($signed(rdata_q.key) < $signed(moving_q.key));
    end
    if (cmd_i.clr_out) begin
      out_q <= '0;
    end else if (cmd_i.ex_root) begin
      out_q <= rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.load_res) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_res) begin
      res_status_q <= cmd_i.res_status;
      res_entry_q  <= out_q;
      res_cnt_q    <= count_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign status_o    = res_status_q;
  assign out_key_o   = res_entry_q.key;
  assign out_tag_o   = res_entry_q.tag;
  assign occupancy_o = res_cnt_q;

endmodule

FILE: sv/min_heap_priority_queue.sv
// min_heap_priority_queue: top level, controller plus datapath.
// Depends on mhpq_pkg, mhpq_if, mhpq_ctrl and mhpq_dp.
//
// Usage:
//   req_i carries one request: func (insert or extract minimum), key, tag.
//   res_o returns one result per request: status, out_key, out_tag and the
//   occupancy after the operation. Keys compare signed; equal keys never swap.
//   One request is in work at a time; req_i.ready is high while the
//   sequencer is idle. The result sits in an output register, so the next
//   request is taken while an earlier result still waits on res_o.
//   Insert climbs toward the root and extract walks the moved entry down
//   toward a leaf, each stopping early when a compare says so. Each level
//   costs one registered read of the single-port heap memory plus a compare
//   (sift-down reads both children). Full-insert and empty-extract requests
//   skip the heap walk and go straight to the done state. After each result
//   is loaded, the sequencer returns to idle before taking the next request.
//   Reset empties the queue at once (count to zero); no memory sweep.
//   If res_o stalls, the finished result holds and the sequencer waits
//   before loading the output register.
module min_heap_priority_queue #(
  parameter int unsigned DEPTH = mhpq_pkg::DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  mhpq_req_if.sink        req_i,
  mhpq_res_if.source      res_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  mhpq_pkg::cmd_t  cmd;
  mhpq_pkg::stat_t stat;

  mhpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_func_i  (req_i.func),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mhpq_dp #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       (req_i.key),
    .tag_i       (req_i.tag),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .status_o    (res_o.status),
    .out_key_o   (res_o.out_key),
    .out_tag_o   (res_o.out_tag),
    .occupancy_o (res_o.occupancy)
  );

  a_ins_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ld_ins |-> !stat.full)
    else $error("insert committed into a full heap");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("second request taken while one is in work");

  a_res_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(cmd.load_res))
    else $error("result valid without a load");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.occupancy <= CNT_W'(DEPTH)))
    else $error("occupancy above depth");

endmodule

FILE: dv/min_heap_priority_queue_tb.sv
// min_heap_priority_queue_tb: self-checking bench for the min-heap priority queue.
// A shadow heap predicts every result; directed and random inserts and extracts
// drive req_i and res_o with random stalls. Depends on mhpq_pkg, mhpq_if and the RTL.
`timescale 1ns / 100ps

module min_heap_priority_queue_tb;

  localparam int unsigned HEAP_DEPTH   = mhpq_pkg::DEPTH_DEF;
  localparam int unsigned KEY_W        = mhpq_pkg::KEY_W;
  localparam int unsigned TAG_W        = mhpq_pkg::TAG_W;
  localparam int unsigned STATUS_W     = mhpq_pkg::STATUS_W;
  localparam int unsigned CNT_W        = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned SEED_N       = 16;
  localparam int unsigned RANDOM_REQS  = 400;
  localparam int unsigned CALM_REQS    = 60;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned REPORT_MAX   = 10;

  localparam logic [KEY_W-1:0] SEED_KEYS [SEED_N] = '{
    32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
    32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000,
    32'h7fff_ffff, 32'h0000_0040, 32'h0000_0020, 32'hffff_fffb,
    32'h8000_0001, 32'h0000_0003, 32'hffff_fffe, 32'h0000_0000
  };
  localparam logic [TAG_W-1:0] SEED_TAGS [SEED_N] = '{
    16'h0000, 16'hffff, 16'h5555, 16'haaaa, 16'h0001, 16'h0002, 16'h0003, 16'h0004,
    16'h8000, 16'h7fff, 16'h1234, 16'hfedc, 16'h00ff, 16'hff00, 16'h0f0f, 16'hf0f0
  };
  localparam logic [KEY_W-1:0] KEY_EXTREMES [4] = '{
    32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff
  };

  typedef struct {
    mhpq_pkg::res_status_e   status;
    logic signed [KEY_W-1:0] key;
    logic        [TAG_W-1:0] tag;
    logic        [CNT_W-1:0] occupancy;
  } outcome_t;

  class heap_tracker;
    mhpq_pkg::entry_t shadow [HEAP_DEPTH];
    int unsigned      held;
    outcome_t         pending [$];
    int unsigned      mismatches;

    function void swap_entries(int unsigned a, int unsigned b);
      mhpq_pkg::entry_t t;
      t         = shadow[a];
      shadow[a] = shadow[b];
      shadow[b] = t;
    endfunction

    function void note_request(logic func, logic signed [KEY_W-1:0] key,
                               logic [TAG_W-1:0] tag);
      outcome_t    o;
      int unsigned pos;
      int unsigned best;
      int unsigned kid;
      bit          settled;
      o.status = mhpq_pkg::RES_INSERTED;
      o.key    = '0;
      o.tag    = '0;
      if (func == mhpq_pkg::FUNC_INSERT) begin
        if (held == HEAP_DEPTH) begin
          o.status = mhpq_pkg::RES_FULL;
        end else begin
          shadow[held].key = key;
          shadow[held].tag = tag;
          pos  = held;
          held = held + 1;
          while (pos > 0 && $signed(shadow[pos].key) < $signed(shadow[(pos - 1) / 2].key)) begin
            swap_entries(pos, (pos - 1) / 2);
            pos = (pos - 1) / 2;
          end
        end
      end else if (held == 0) begin
        o.status = mhpq_pkg::RES_EMPTY;
      end else begin
        o.status  = mhpq_pkg::RES_EXTRACTED;
        o.key     = shadow[0].key;
        o.tag     = shadow[0].tag;
        shadow[0] = shadow[held - 1];
        held      = held - 1;
        pos       = 0;
        settled   = 1'b0;
        while (!settled) begin
          best = pos;
          for (kid = 2 * pos + 1; kid <= 2 * pos + 2; kid++) begin
            if (kid < held && $signed(shadow[kid].key) < $signed(shadow[best].key)) best = kid;
          end
          if (best == pos) begin
            settled = 1'b1;
          end else begin
            swap_entries(pos, best);
            pos = best;
          end
        end
      end
      o.occupancy = CNT_W'(held);
      pending.push_back(o);
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= REPORT_MAX) $display("[%0t] mismatch: %s", $time, what);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic signed [KEY_W-1:0] key,
                               logic [TAG_W-1:0] tag, logic [CNT_W-1:0] occupancy);
      outcome_t o;
      if (pending.size() == 0) begin
        report($sformatf("result with none pending: status %0d key %0d tag %h occupancy %0d",
                         status, key, tag, occupancy));
      end else begin
        o = pending.pop_front();
        if (status !== o.status)
          report($sformatf("status expected %0d got %0d", o.status, status));
        if (key !== o.key)
          report($sformatf("out_key expected %0d got %0d", o.key, key));
        if (tag !== o.tag)
          report($sformatf("out_tag expected %h got %h", o.tag, tag));
        if (occupancy !== o.occupancy)
          report($sformatf("occupancy expected %0d got %0d", o.occupancy, occupancy));
      end
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  bit                      calm = 1'b0;
  int unsigned             cycles = 0;
  logic signed [KEY_W-1:0] last_key = '0;
  heap_tracker             board = new();

  mhpq_req_if                         req ();
  mhpq_res_if #(.DEPTH(HEAP_DEPTH))   res ();

  min_heap_priority_queue #(.DEPTH(HEAP_DEPTH)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .res_o  (res)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[min_heap_priority_queue] ERROR");
      $finish;
    end
  end

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 4))
      0:       pick_key = KEY_W'($urandom_range(0, 6)) - KEY_W'(3);
      1:       pick_key = KEY_EXTREMES[$urandom_range(0, 3)];
      2:       pick_key = last_key;
      default: pick_key = $urandom;
    endcase
  endfunction

  task automatic push_request(input logic func, input logic signed [KEY_W-1:0] key,
                              input logic [TAG_W-1:0] tag);
    if (!calm && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.func  <= func;
    req.key   <= key;
    req.tag   <= tag;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    board.note_request(func, key, tag);
    last_key = key;
  endtask

  initial begin
    int unsigned hold;
    hold = 0;
    res.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (res.valid && res.ready)
        board.check_result(res.status, res.out_key, res.out_tag, res.occupancy);
      if (hold > 0) begin
        hold--;
        res.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(0, 12);
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned run;
    int unsigned insert_pct;
    logic        func;
    rst_ni    <= 1'b0;
    req.valid <= 1'b0;
    req.func  <= mhpq_pkg::FUNC_INSERT;
    req.key   <= '0;
    req.tag   <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_request(mhpq_pkg::FUNC_EXTRACT, '1, '1);
    for (int i = 0; i < SEED_N; i++) begin
      push_request(mhpq_pkg::FUNC_INSERT, SEED_KEYS[i], SEED_TAGS[i]);
    end
    push_request(mhpq_pkg::FUNC_INSERT, 32'h8000_0000, '1);
    repeat (6) push_request(mhpq_pkg::FUNC_EXTRACT, pick_key(), TAG_W'($urandom));

    // pick fill, drain and mixed runs at random so the heap swings between empty and deep
    sent = 0;
    while (sent < RANDOM_REQS) begin
      case ($urandom_range(0, 2))
        0:       insert_pct = 85;
        1:       insert_pct = 15;
        default: insert_pct = 50;
      endcase
      run = $urandom_range(4, 40);
      while (run > 0 && sent < RANDOM_REQS) begin
        calm = (sent >= RANDOM_REQS - CALM_REQS);
        func = ($urandom_range(0, 99) < insert_pct) ? mhpq_pkg::FUNC_INSERT
                                                    : mhpq_pkg::FUNC_EXTRACT;
        push_request(func, pick_key(), TAG_W'($urandom));
        run--;
        sent++;
      end
    end
    req.valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("[min_heap_priority_queue] OK");
    end else begin
      $display("[min_heap_priority_queue] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/mhpq_pkg.sv
sv/mhpq_if.sv
sv/mhpq_ctrl.sv
sv/mhpq_dp.sv
sv/min_heap_priority_queue.sv
dv/min_heap_priority_queue_tb.sv
